// File: sv/nsc_pkg.sv
`default_nettype none
package nsc_pkg;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_V      = 8'h56;

	localparam int HDR_LEN = 5;
	localparam logic [2:0] POS_MAX      = 3'd6;
	localparam logic [2:0] POS_TALKER   = 3'd3;
	localparam logic [2:0] POS_TYPE     = 3'd6;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_BODY  = 4'b0010,
		PH_HEX   = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_START = 2'd1,
		ST_NO_STAR   = 2'd2,
		ST_MISMATCH  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TY_GGA   = 2'd0,
		TY_VTG   = 2'd1,
		TY_GSV   = 2'd2,
		TY_OTHER = 2'd3
	} sentence_t;

	typedef enum logic [2:0] {
		TK_GP      = 3'd0,
		TK_GN      = 3'd1,
		TK_GL      = 3'd2,
		TK_BD      = 3'd3,
		TK_GA      = 3'd4,
		TK_UNKNOWN = 3'd5
	} talker_t;

	typedef struct packed {
		phase_t                    phase;
		logic [7:0]                xor_acc;
		logic [7:0]                cks_field;
		logic [1:0]                hex_cnt;
		logic [HDR_LEN-1:0][7:0]   hdr;
		logic [2:0]                pos;
		logic                      dollar;
		logic                      start_ok;
	} line_state_t;

	localparam line_state_t LINE_IDLE = '{phase: PH_START, default: '0};

	typedef struct packed {
		status_t    status;
		sentence_t  sentence_type;
		talker_t    talker;
		logic [7:0] received_checksum;
		logic [7:0] computed_checksum;
	} result_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				v = c - 8'h30;
				return {1'b1, v[3:0]};
			end
			if (c >= 8'h41 && c <= 8'h46) begin
				v = c - 8'h37;
				return {1'b1, v[3:0]};
			end
			if (c >= 8'h61 && c <= 8'h66) begin
				v = c - 8'h57;
				return {1'b1, v[3:0]};
			end
			return 5'd0;
		end
	endfunction

endpackage
`default_nettype wire

// File: sv/nsc_parser.sv
`default_nettype none
module nsc_parser
	import nsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  rx_char,
	output line_state_t      line_q
);

	line_state_t nxt;
	logic [4:0]  hd;

	always_comb begin
		nxt = line_q;
		hd  = hex_digit(rx_char);
		if (rx_char == CH_LF) begin
			nxt = LINE_IDLE;
		end else begin
			for (int i = 0; i < HDR_LEN; i++) begin
				if (line_q.pos == 3'(i + 1)) begin
					nxt.hdr[i] = rx_char;
				end
			end
			if (line_q.pos < POS_MAX) begin
				nxt.pos = line_q.pos + 3'd1;
			end
			unique case (line_q.phase)
				PH_START: begin
					if (rx_char == CH_DOLLAR || rx_char == CH_BANG) begin
						nxt.start_ok = 1'b1;
						nxt.dollar   = (rx_char == CH_DOLLAR);
						nxt.phase    = PH_BODY;
					end else begin
						nxt.phase = PH_SKIP;
					end
				end
				PH_BODY: begin
					if (rx_char == CH_STAR) begin
						nxt.phase = PH_HEX;
					end else begin
						nxt.xor_acc = line_q.xor_acc ^ rx_char;
					end
				end
				PH_HEX: begin
					if (!hd[4]) begin
						nxt.phase = PH_SKIP;
					end else begin
						nxt.cks_field = {line_q.cks_field[3:0], hd[3:0]};
						nxt.hex_cnt   = line_q.hex_cnt + 2'd1;
						if (line_q.hex_cnt != 2'd0) begin
							nxt.phase = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
				end
				default: begin
					nxt.phase = PH_SKIP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_IDLE;
		end else if (take) begin
			line_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: sv/nsc_classify.sv
`default_nettype none
module nsc_classify
	import nsc_pkg::*;
(
	input  wire line_state_t line,
	output result_t          res
);

	always_comb begin
		res.sentence_type = TY_OTHER;
		res.talker        = TK_UNKNOWN;
		if (!line.start_ok) begin
			res.status = ST_BAD_START;
		end else if (line.phase == PH_BODY) begin
			res.status = ST_NO_STAR;
		end else if (line.cks_field != line.xor_acc) begin
			res.status = ST_MISMATCH;
		end else begin
			res.status = ST_OK;
		end

		if (res.status == ST_OK) begin
			if (line.dollar && line.pos >= POS_TALKER) begin
				if (line.hdr[0] == CH_G && line.hdr[1] == CH_P) begin
					res.talker = TK_GP;
				end else if (line.hdr[0] == CH_G && line.hdr[1] == CH_N) begin
					res.talker = TK_GN;
				end else if (line.hdr[0] == CH_G && line.hdr[1] == CH_L) begin
					res.talker = TK_GL;
				end else if (line.hdr[0] == CH_B && line.hdr[1] == CH_D) begin
					res.talker = TK_BD;
				end else if (line.hdr[0] == CH_G && line.hdr[1] == CH_A) begin
					res.talker = TK_GA;
				end
			end
			if (line.pos >= POS_TYPE) begin
				if (line.hdr[2] == CH_G && line.hdr[3] == CH_G && line.hdr[4] == CH_A) begin
					res.sentence_type = TY_GGA;
				end else if (line.hdr[2] == CH_V && line.hdr[3] == CH_T
						&& line.hdr[4] == CH_G) begin
					res.sentence_type = TY_VTG;
				end else if (line.hdr[2] == CH_G && line.hdr[3] == CH_S
						&& line.hdr[4] == CH_V) begin
					res.sentence_type = TY_GSV;
				end
			end
		end

		res.received_checksum = line.start_ok ? line.cks_field : 8'd0;
		res.computed_checksum = line.start_ok ? line.xor_acc : 8'd0;
	end

endmodule
`default_nettype wire

// File: sv/nmea_sentence_checker_top.sv
// A line-feed byte is registered in the input register, and its result then in the result register.
// Throughput: one byte per cycle; a byte enters the input register at every edge
// unless a line feed waits there while the result register is full and stalled.
// Reset (arst_n low, asynchronous) empties both registers and returns the line
// parser to the start of a line.
`default_nettype none
module nmea_sentence_checker_top
	import nsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [1:0]      sentence_type,
	output logic [2:0]      talker,
	output logic [7:0]      received_checksum,
	output logic [7:0]      computed_checksum
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        is_lf;
	logic        take;
	line_state_t line_q;
	result_t     res;
	result_t     res_q;

	assign out_free = !out_valid || !out_stall;
	assign is_lf    = (byte_s1 == CH_LF);
	assign take     = valid_s1 && (!is_lf || out_free);
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nsc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_char (byte_s1),
		.line_q  (line_q)
	);

	nsc_classify u_classify (
		.line (line_q),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= take && is_lf;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take && is_lf) begin
			res_q <= res;
		end
	end

	assign status            = res_q.status;
	assign sentence_type     = res_q.sentence_type;
	assign talker            = res_q.talker;
	assign received_checksum = res_q.received_checksum;
	assign computed_checksum = res_q.computed_checksum;

	a_not_ok_no_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> sentence_type == TY_OTHER && talker == TK_UNKNOWN)
		else $error("classification reported on a failed line");

	a_bad_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_START |->
			received_checksum == 8'd0 && computed_checksum == 8'd0)
		else $error("checksums not cleared on a bad start");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> received_checksum == computed_checksum)
		else $error("status ok with differing checksums");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && is_lf && out_valid && out_stall)
		else $error("input stalled without a blocked line feed");

endmodule
`default_nettype wire

// File: tb/sv/nmea_line_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module nmea_line_checker
	import nsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [1:0] status,
	input  wire logic [1:0] sentence_type,
	input  wire logic [2:0] talker,
	input  wire logic [7:0] received_checksum,
	input  wire logic [7:0] computed_checksum,
	output int              fail_count,
	output int              pending_lines
);

	result_t    line_results[$];
	int         errors = 0;
	int         waiting = 0;

	phase_t     line_phase;
	logic [7:0] line_xor;
	logic [7:0] line_cks;
	logic [1:0] digits_seen;
	logic [7:0] head [HDR_LEN];
	logic [2:0] line_pos;
	logic       from_dollar;
	logic       opened;

	assign fail_count = errors;
	assign pending_lines = waiting;

	task automatic clear_line();
		line_phase = PH_START;
		line_xor = 8'h00;
		line_cks = 8'h00;
		digits_seen = 2'd0;
		foreach (head[i])
			head[i] = 8'h00;
		line_pos = 3'd0;
		from_dollar = 1'b0;
		opened = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t    want;
		status_t    line_status;
		talker_t    line_talker;
		sentence_t  line_kind;
		logic [4:0] digit;
		if (!arst_n) begin
			clear_line();
			line_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (line_results.size() == 0) begin
					$error("Result beat with no line pending: status %0d", status);
					errors++;
				end else begin
					want = line_results.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("sentence_type", 8'(want.sentence_type),
						8'(sentence_type));
					check_field("talker", 8'(want.talker), 8'(talker));
					check_field("received_checksum", want.received_checksum,
						received_checksum);
					check_field("computed_checksum", want.computed_checksum,
						computed_checksum);
				end
			end
			if (in_valid && !in_stall) begin
				if (rx_byte == CH_LF) begin
					line_talker = TK_UNKNOWN;
					line_kind = TY_OTHER;
					if (!opened)
						line_status = ST_BAD_START;
					else if (line_phase == PH_BODY)
						line_status = ST_NO_STAR;
					else if (line_cks != line_xor)
						line_status = ST_MISMATCH;
					else
						line_status = ST_OK;
					if (line_status == ST_OK) begin
						if (from_dollar && line_pos >= POS_TALKER) begin
							case ({head[0], head[1]})
								"GP": line_talker = TK_GP;
								"GN": line_talker = TK_GN;
								"GL": line_talker = TK_GL;
								"BD": line_talker = TK_BD;
								"GA": line_talker = TK_GA;
								default: line_talker = TK_UNKNOWN;
							endcase
						end
						if (line_pos >= POS_TYPE) begin
							case ({head[2], head[3], head[4]})
								"GGA": line_kind = TY_GGA;
								"VTG": line_kind = TY_VTG;
								"GSV": line_kind = TY_GSV;
								default: line_kind = TY_OTHER;
							endcase
						end
					end
					want.status = line_status;
					want.sentence_type = line_kind;
					want.talker = line_talker;
					want.received_checksum = opened ? line_cks : 8'h00;
					want.computed_checksum = opened ? line_xor : 8'h00;
					line_results = {line_results, want};
					clear_line();
				end else begin
					if (line_pos >= 3'd1 && line_pos <= 3'd5)
						head[line_pos - 3'd1] = rx_byte;
					if (line_pos < POS_MAX)
						line_pos++;
					case (line_phase)
						PH_START: begin
							if (rx_byte == CH_DOLLAR || rx_byte == CH_BANG) begin
								opened = 1'b1;
								from_dollar = (rx_byte == CH_DOLLAR);
								line_phase = PH_BODY;
							end else begin
								line_phase = PH_SKIP;
							end
						end
						PH_BODY: begin
							if (rx_byte == CH_STAR)
								line_phase = PH_HEX;
							else
								line_xor ^= rx_byte;
						end
						PH_HEX: begin
							digit = 5'd0;
							if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
								digit = {1'b1, rx_byte[3:0]};
							else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
									(rx_byte >= 8'h61 && rx_byte <= 8'h66))
								digit = {1'b1, rx_byte[3:0] + 4'd9};
							if (!digit[4]) begin
								line_phase = PH_SKIP;
							end else begin
								line_cks = {line_cks[3:0], digit[3:0]};
								digits_seen++;
								if (digits_seen == 2'd2)
									line_phase = PH_SKIP;
							end
						end
						default: ;
					endcase
				end
			end
		end
		waiting = line_results.size();
	end

endmodule
`default_nettype wire

// File: tb/sv/tb_nmea_sentence_checker_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_nmea_sentence_checker_top
	import nsc_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] status;
	logic [1:0] sentence_type;
	logic [2:0] talker;
	logic [7:0] received_checksum;
	logic [7:0] computed_checksum;

	int         fail_count;
	int         pending_lines;
	logic       in_beat = 1'b0;
	int         cycles = 0;
	int         bytes_sent = 0;
	int         lines_sent = 0;
	int         stall_left = 0;
	bit         tx_idle_on = 1'b1;
	bit         rx_idle_on = 1'b1;
	bit         hold_request = 1'b0;
	logic [7:0] line_bytes[$];

	nmea_sentence_checker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.sentence_type(sentence_type),
		.talker(talker),
		.received_checksum(received_checksum),
		.computed_checksum(computed_checksum)
	);

	nmea_line_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.sentence_type(sentence_type),
		.talker(talker),
		.received_checksum(received_checksum),
		.computed_checksum(computed_checksum),
		.fail_count(fail_count),
		.pending_lines(pending_lines)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		in_beat <= in_valid && !in_stall;
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls in short random bursts, or once for a long stretch on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (rx_idle_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) begin
			do
				b = 8'($urandom);
			while (b == CH_LF || b == CH_STAR);
		end else begin
			do
				b = 8'($urandom_range(8'h20, 8'h7E));
			while (b == CH_STAR);
		end
		return b;
	endfunction

	function automatic logic [7:0] upper_letter();
		return 8'($urandom_range(CH_A, 8'h5A));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] body_xor();
		logic [7:0] x;
		x = 8'h00;
		for (int i = 1; i < line_bytes.size(); i++)
			x ^= line_bytes[i];
		return x;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		line_bytes = {line_bytes, b};
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_hex(input logic [7:0] v, input bit lower);
		add_byte(hex_char(v[7:4], lower));
		add_byte(hex_char(v[3:0], lower));
	endtask

	task automatic seal(input bit lower);
		logic [7:0] cs;
		cs = body_xor();
		add_byte(CH_STAR);
		add_hex(cs, lower);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic put_byte(input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			rx_byte = 8'($urandom);
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do
			@(negedge clk);
		while (!in_beat);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_bytes[i])
			put_byte(line_bytes[i]);
		put_byte(CH_LF);
		lines_sent++;
		line_bytes.delete();
	endtask

	task automatic random_line();
		int kind;
		int pick;
		bit lower;
		logic [7:0] cs;
		kind = $urandom_range(0, 9);
		lower = 1'($urandom_range(0, 1));
		if (kind <= 6) begin
			add_byte(($urandom_range(0, 3) == 0) ? CH_BANG : CH_DOLLAR);
			if ($urandom_range(0, 9) != 0) begin
				case ($urandom_range(0, 5))
					0: add_str("GP");
					1: add_str("GN");
					2: add_str("GL");
					3: add_str("BD");
					4: add_str("GA");
					default: begin
						add_byte(upper_letter());
						add_byte(upper_letter());
					end
				endcase
				case ($urandom_range(0, 3))
					0: add_str("GGA");
					1: add_str("VTG");
					2: add_str("GSV");
					default: begin
						repeat ($urandom_range(0, 3))
							add_byte(upper_letter());
					end
				endcase
			end
			repeat ($urandom_range(0, 8))
				add_byte(body_byte());
			pick = $urandom_range(0, 9);
			cs = body_xor();
			if (pick != 0) begin
				add_byte(CH_STAR);
				case (pick)
					1: add_hex(cs ^ 8'($urandom_range(1, 255)), lower);
					2: add_byte(hex_char(4'($urandom), lower));
					3: begin
						add_hex(cs, lower);
						add_str("*1,x");
					end
					default: add_hex(cs, lower);
				endcase
			end
			if ($urandom_range(0, 1) == 0)
				add_byte(8'h0D);
		end else if (kind <= 8) begin
			repeat ($urandom_range(0, 8))
				add_byte(any_byte());
		end else begin
			add_byte(CH_DOLLAR);
			repeat ($urandom_range(0, 6)) begin
				pick = $urandom_range(0, 3);
				if (pick == 0)
					add_byte(CH_STAR);
				else if (pick == 1)
					add_byte(hex_char(4'($urandom), lower));
				else
					add_byte(any_byte());
			end
		end
		send_line();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_line();
		line_bytes = '{8'hFF, 8'h00};
		send_line();
		add_str("$GPGGA,1");
		seal(1'b0);
		send_line();
		add_str("!GPGGA");
		seal(1'b0);
		send_line();
		line_bytes = '{CH_BANG, 8'h80, 8'hFF};
		seal(1'b1);
		send_line();
		add_str("$BDVTG");
		seal(1'b1);
		add_byte(8'h0D);
		send_line();
		add_str("$GLGSV");
		seal(1'b0);
		send_line();
		add_str("$GN");
		seal(1'b0);
		send_line();
		add_str("$GAxyz");
		seal(1'b1);
		add_str("*7");
		send_line();
		add_str("$AB");
		add_byte(8'h0D);
		send_line();
		add_str("$*1G");
		send_line();
		add_str("x$GP*00");
		send_line();

		while (bytes_sent < 250)
			random_line();
		hold_request = 1'b1;
		while (bytes_sent < 420)
			random_line();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (bytes_sent < 500)
			random_line();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (bytes_sent < 560)
			random_line();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (bytes_sent < 650 || lines_sent < 60)
			random_line();
		in_valid = 1'b0;

		wait (pending_lines == 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
